[rtl/nsad_pkg.sv]
// Shared types, codes and constants for the noise-shaped audio dither block.
// Used by nsad_state, nsad_shaper and noise_shaped_audio_dither.
package nsad_pkg;

  localparam int MAX_CHANNELS = 9;
  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

  localparam int ACC_W    = 36;

  localparam logic [20:0] LCG_MUL = 21'h19660d;
  localparam logic [31:0] LCG_ADD = 32'h3c6ef35f;

  localparam logic signed [ACC_W-1:0] Q_ONE     = 36'sh0_4000_0000;
  localparam logic signed [ACC_W-1:0] LSB_EIGHT = 36'sh0_0080_0000;
  localparam logic signed [ACC_W-1:0] LSB_SIXTN = 36'sh0_0000_8000;

  // register indexes on the configuration port
  localparam logic [1:0] REG_ENABLE       = 2'd0;
  localparam logic [1:0] REG_TARGET_DEPTH = 2'd1;
  localparam logic [1:0] REG_NUM_CHANNELS = 2'd2;

  // target depth codes
  localparam logic [1:0] DEPTH_NONE    = 2'd0;
  localparam logic [1:0] DEPTH_EIGHT   = 2'd1;
  localparam logic [1:0] DEPTH_SIXTEEN = 2'd2;

  typedef struct packed {
    logic [31:0] err_now;
    logic [31:0] err_half;
    logic [31:0] err_old;
    logic [31:0] lcg;
  } chan_state_t;

endpackage

[rtl/nsad_state.sv]
// Per-channel history file: three error-feedback terms and the generator state.
// One read and one write at the working channel; depends on nsad_pkg.
module nsad_state
  import nsad_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic [CH_W-1:0]   ch,
  input  logic              wr_en,
  input  chan_state_t       wr_data,
  output chan_state_t       rd_data
);

  chan_state_t entries [MAX_CHANNELS];

  assign rd_data = entries[ch];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        entries[i] <= '0;
      end
    end else if (wr_en) begin
      entries[ch] <= wr_data;
    end
  end

endmodule

[rtl/nsad_shaper.sv]
// Noise-shaping, dither and clip arithmetic for one sample.
// Combinational; depends on nsad_pkg.
module nsad_shaper
  import nsad_pkg::*;
(
  input  logic [31:0]  sample,
  input  logic         enable,
  input  logic [1:0]   target_depth,
  input  chan_state_t  cur,
  output logic [31:0]  result,
  output logic         update,
  output chan_state_t  nxt
);

  logic signed [ACC_W-1:0] x_s, en_s, eh_s, eo_s;
  logic signed [ACC_W-1:0] shaped, clamped, lsb, dith, out_sum, out_clip, err;
  logic [31:0]             prod;
  logic [31:0]             rnd, diff;

  assign x_s  = ACC_W'(signed'(sample));
  assign en_s = ACC_W'(signed'(cur.err_now));
  assign eh_s = ACC_W'(signed'(cur.err_half));
  assign eo_s = ACC_W'(signed'(cur.err_old));

  // only the low word of the generator product is kept
  assign prod = cur.lcg * 32'(LCG_MUL);
  assign rnd  = prod + LCG_ADD;
  assign diff = rnd - cur.lcg;

  always_comb begin
    // diff * lsb >> 32 is a plain shift since lsb is a power of two
    case (target_depth)
      DEPTH_EIGHT: begin
        lsb  = LSB_EIGHT;
        dith = signed'({13'b0, diff[31:9]});
      end
      DEPTH_SIXTEEN: begin
        lsb  = LSB_SIXTN;
        dith = signed'({21'b0, diff[31:17]});
      end
      default: begin
        lsb  = '0;
        dith = '0;
      end
    endcase
  end

  assign update  = enable && (lsb != '0);
  assign shaped  = x_s + en_s - eh_s + eo_s;
  assign out_sum = shaped + lsb + dith;

  always_comb begin
    clamped  = shaped;
    out_clip = out_sum;
    if (out_sum > Q_ONE) begin
      out_clip = Q_ONE;
      if (shaped > Q_ONE) clamped = Q_ONE;
    end else if (out_sum < -Q_ONE) begin
      out_clip = -Q_ONE;
      if (shaped < -Q_ONE) clamped = -Q_ONE;
    end
  end

  assign err = clamped - out_clip;

  assign result = update ? out_clip[31:0] : sample;

  assign nxt.err_now  = err[31:0];
  assign nxt.err_half = {cur.err_now[31], cur.err_now[31:1]};
  assign nxt.err_old  = cur.err_half;
  assign nxt.lcg      = rnd;

endmodule

[rtl/noise_shaped_audio_dither.sv]
// Noise-shaped linear dither for interleaved Q2.30 audio (1.0 = 2^30).
// An item is taken into an input register with its channel number, then
// shaped, dithered and clipped combinationally and placed in the output register;
// one item is accepted every cycle, and only a stalled
// output holds the input side. Channel history (three error terms and an LCG
// per channel) lives in flip-flops, read and rewritten in the same cycle, so
// back-to-back items of one channel see each other's updates. Writing
// num_channels clears all history and restarts the channel counter; the
// configuration port is always ready and is meant to be written while idle.
// Depends on nsad_pkg, nsad_state and nsad_shaper.
module noise_shaped_audio_dither
  import nsad_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] sample_in,
  input  logic        buffer_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] sample_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic             enable;
  logic [1:0]       target_depth;
  logic [3:0]       num_channels;
  logic [CH_W-1:0]  chan_index;

  logic             s1_valid;
  logic [31:0]      s1_sample;
  logic [CH_W-1:0]  s1_ch;

  logic             advance, in_fire, cfg_fire, clear;
  logic [CNT_W-1:0] eff_count, ch_wide, ch_inc;
  logic [CH_W-1:0]  ch_sel;

  chan_state_t      cur_state, nxt_state;
  logic [31:0]      result;
  logic             update;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign clear     = cfg_fire && (cfg_index == REG_NUM_CHANNELS);

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    if (num_channels == '0) begin
      eff_count = CNT_W'(1);
    end else if (32'(num_channels) > 32'(MAX_CHANNELS)) begin
      eff_count = CNT_W'(MAX_CHANNELS);
    end else begin
      eff_count = CNT_W'(num_channels);
    end
  end

  // a counter at or past the count falls back to channel zero
  always_comb begin
    ch_wide = buffer_start ? '0 : CNT_W'(chan_index);
    if (ch_wide >= eff_count) ch_wide = '0;
    ch_sel = CH_W'(ch_wide);
    ch_inc = ch_wide + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      target_depth <= DEPTH_NONE;
      num_channels <= 4'd2;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_ENABLE:       enable       <= cfg_data[0];
        REG_TARGET_DEPTH: target_depth <= cfg_data[1:0];
        REG_NUM_CHANNELS: num_channels <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      chan_index <= '0;
    end else if (in_fire) begin
      chan_index <= (ch_inc >= eff_count) ? '0 : CH_W'(ch_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample <= sample_in;
      s1_ch     <= ch_sel;
    end
  end

  nsad_state u_state (
    .clk     (clk),
    .rst     (rst),
    .clear   (clear),
    .ch      (s1_ch),
    .wr_en   (s1_valid && advance && update),
    .wr_data (nxt_state),
    .rd_data (cur_state)
  );

  nsad_shaper u_shaper (
    .sample       (s1_sample),
    .enable       (enable),
    .target_depth (target_depth),
    .cur          (cur_state),
    .result       (result),
    .update       (update),
    .nxt          (nxt_state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      sample_out <= result;
    end
  end

endmodule

[verif/dither_checker.sv]
`timescale 1ns / 100ps
// Checker for noise_shaped_audio_dither: watches the item, result and register
// channels, predicts every dithered sample and compares it. Depends on nsad_pkg.
module dither_checker
  import nsad_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] sample_in,
  input  logic        buffer_start,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] sample_out,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  localparam logic [31:0] LCG_MULT = 32'h0019_660d;
  localparam logic [31:0] LCG_INC  = 32'h3c6e_f35f;
  localparam longint      Q_UNITY  = 64'sd1073741824;

  logic        en;
  logic [1:0]  depth;
  logic [3:0]  num_ch;
  logic [31:0] fb_now   [MAX_CHANNELS];
  logic [31:0] fb_half  [MAX_CHANNELS];
  logic [31:0] fb_old   [MAX_CHANNELS];
  logic [31:0] lcg_seed [MAX_CHANNELS];
  int          next_chan;

  logic [31:0] dithered_q [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic clear_history();
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      fb_now[i]   = '0;
      fb_half[i]  = '0;
      fb_old[i]   = '0;
      lcg_seed[i] = '0;
    end
    next_chan = 0;
  endtask

  task automatic apply_reg(input logic [1:0] idx, input logic [31:0] data);
    case (idx)
      REG_ENABLE:       en = data[0];
      REG_TARGET_DEPTH: depth = data[1:0];
      REG_NUM_CHANNELS: begin
        num_ch = data[3:0];
        clear_history();
      end
      default: ;
    endcase
  endtask

  task automatic dither_sample(input logic [31:0] x, input logic bs, output logic [31:0] y);
    int          count;
    int          ch;
    longint      lsb;
    longint      shaped;
    longint      o;
    longint      d;
    longint      resid;
    logic [31:0] old_lcg;
    logic [31:0] rnd;
    logic [31:0] diff;
    count = (num_ch == 0) ? 1 : ((num_ch > MAX_CHANNELS) ? MAX_CHANNELS : int'(num_ch));
    if (bs)
      next_chan = 0;
    ch = (next_chan >= count) ? 0 : next_chan;
    next_chan = (ch + 1 >= count) ? 0 : ch + 1;

    case (depth)
      DEPTH_EIGHT:   lsb = 64'sd1 << 23;
      DEPTH_SIXTEEN: lsb = 64'sd1 << 15;
      default:       lsb = 0;
    endcase

    if (!en || lsb == 0) begin
      y = x;
    end else begin
      shaped = longint'(signed'(x)) + longint'(signed'(fb_now[ch]))
             - longint'(signed'(fb_half[ch])) + longint'(signed'(fb_old[ch]));
      old_lcg = lcg_seed[ch];
      rnd = old_lcg * LCG_MULT + LCG_INC;
      diff = rnd - old_lcg;
      d = (longint'({32'd0, diff}) * lsb) >> 32;

      fb_old[ch]   = fb_half[ch];
      fb_half[ch]  = {fb_now[ch][31], fb_now[ch][31:1]};
      lcg_seed[ch] = rnd;

      o = shaped + lsb + d;
      // clamp the shaped sample to the rail before forming the new error
      if (o > Q_UNITY) begin
        o = Q_UNITY;
        if (shaped > Q_UNITY)
          shaped = Q_UNITY;
      end else if (o < -Q_UNITY) begin
        o = -Q_UNITY;
        if (shaped < -Q_UNITY)
          shaped = -Q_UNITY;
      end
      resid = shaped - o;
      fb_now[ch] = resid[31:0];
      y = o[31:0];
    end
  endtask

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      en = 1'b0;
      depth = DEPTH_NONE;
      num_ch = 4'd2;
      clear_history();
      dithered_q.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        apply_reg(cfg_index, cfg_data);
      // retire before predicting: an item taken this edge cannot leave yet
      if (out_valid && out_ready) begin
        if (dithered_q.size() == 0) begin
          report_mismatch("unexpected item", sample_out, '0);
        end else begin
          want = dithered_q.pop_front();
          if (sample_out !== want)
            report_mismatch("sample_out", sample_out, want);
        end
      end
      if (in_valid && in_ready) begin
        dither_sample(sample_in, buffer_start, want);
        dithered_q.push_back(want);
      end
    end
    pending <= dithered_q.size();
  end

endmodule

[verif/noise_shaped_audio_dither_tb.sv]
`timescale 1ns / 100ps
// Testbench top for noise_shaped_audio_dither: clock, reset, register settings,
// sample stimulus with random idling, and the verdict. Uses dither_checker and nsad_pkg.
module noise_shaped_audio_dither_tb;
  import nsad_pkg::*;

  localparam logic [1:0] REG_UNUSED   = 2'd3;
  localparam logic [1:0] DEPTH_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] sample_in = '0;
  logic        buffer_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] sample_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int mismatches;
  int pending;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int chans_now = 2;
  bit drain_stuck = 1'b0;

  noise_shaped_audio_dither dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_in    (sample_in),
    .buffer_start (buffer_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_out   (sample_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  dither_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_in    (sample_in),
    .buffer_start (buffer_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_out   (sample_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // random upper bits ride along on every register write
  task automatic set_mode(input bit en, input logic [1:0] depth, input logic [3:0] nch,
                          input bit clear);
    logic [31:0] r;
    r = $urandom;
    r[0] = en;
    write_reg(REG_ENABLE, r);
    r = $urandom;
    r[1:0] = depth;
    write_reg(REG_TARGET_DEPTH, r);
    if (clear) begin
      r = $urandom;
      r[3:0] = nch;
      write_reg(REG_NUM_CHANNELS, r);
      chans_now = (nch == 0) ? 1 : ((nch > MAX_CHANNELS) ? MAX_CHANNELS : int'(nch));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input logic [31:0] x, input bit bs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_in    <= x;
    buffer_start <= bs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (pending != 0)
      drain_stuck = 1'b1;
  endtask

  function automatic logic [31:0] pick_sample();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0, 1, 2: ;
      3, 4:    v = $urandom_range(2097152) - 32'd1048576;
      5, 6:    v = ($urandom_range(1) ? 32'h4000_0000 : 32'hc000_0000)
                   + $urandom_range(131072) - 32'd65536;
      7:       v = {{2{v[31]}}, v[29:0]};
      8: begin
        case ($urandom_range(3))
          0:       v = 32'h7fff_ffff;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      default: v = $urandom_range(510) - 32'd255;
    endcase
    return v;
  endfunction

  // mostly well-framed buffers, with a few stray buffer starts
  task automatic run_random(input int n);
    int pos;
    int frame;
    bit bs;
    pos = 0;
    frame = chans_now * $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      bs = (pos == 0) || ($urandom_range(99) < 4);
      send_item(pick_sample(), bs);
      pos = (pos + 1 >= frame) ? 0 : pos + 1;
      if (pos == 0)
        frame = chans_now * $urandom_range(1, 8);
    end
    drain();
  endtask

  task automatic phase(input int k, input bit en, input logic [1:0] depth,
                       input logic [3:0] nch, input bit clear, input int n);
    case (k % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 52; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 52; end
      default: begin send_idle_pct = 15; stall_pct = 15; end
    endcase
    set_mode(en, depth, nch, clear);
    run_random(n);
  endtask

  initial begin
    logic [31:0] corner_vals [16] = '{
      32'h0000_0000, 32'h0000_0000, 32'h4000_0000, 32'h4000_0000,
      32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
      32'hc000_0000, 32'hbfff_ffff, 32'h3f80_0000, 32'h3fff_ffff,
      32'hc080_0000, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0000
    };
    logic [31:0] fine_vals [6] = '{
      32'h3fff_ffff, 32'h3fff_8000, 32'h7fff_ffff,
      32'h8000_0000, 32'hc000_7fff, 32'h0000_0000
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // settings after reset pass samples through untouched
    send_item(32'h7fff_ffff, 1'b1);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h1234_5678, 1'b0);
    drain();

    // rails, clamping beyond the rail, and a buffer start mid-stream
    set_mode(1'b1, DEPTH_EIGHT, 4'd2, 1'b1);
    for (int i = 0; i < 16; i++)
      send_item(corner_vals[i], (i == 0) || (i == 9));
    drain();
    set_mode(1'b1, DEPTH_SIXTEEN, 4'd3, 1'b1);
    for (int i = 0; i < 6; i++)
      send_item(fine_vals[i], i == 0);
    drain();

    phase(0, 1'b1, DEPTH_SIXTEEN, 4'd2,  1'b1, 75);
    phase(1, 1'b1, DEPTH_EIGHT,   4'd9,  1'b1, 75);
    phase(2, 1'b1, DEPTH_SIXTEEN, 4'd1,  1'b1, 75);
    phase(3, 1'b0, DEPTH_SIXTEEN, 4'd4,  1'b1, 75);
    phase(4, 1'b1, DEPTH_SIXTEEN, 4'd4,  1'b0, 75);
    phase(5, 1'b1, DEPTH_NONE,    4'd3,  1'b1, 75);
    write_reg(REG_UNUSED, $urandom);
    phase(6, 1'b1, DEPTH_UNUSED,  4'd5,  1'b1, 75);
    phase(7, 1'b1, DEPTH_EIGHT,   4'd0,  1'b1, 75);
    phase(8, 1'b1, DEPTH_SIXTEEN, 4'd15, 1'b1, 75);
    phase(9, 1'b1, DEPTH_EIGHT,   4'd7,  1'b0, 75);

    repeat (10) @(posedge clk);
    if (mismatches == 0 && !drain_stuck)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
